// ===== src/rgpl_pkg.sv =====
// shared types and constants for the rectilinear grid point locator
// no dependencies; imported by rgpl_axis_cell and rect_grid_point_locate
package rgpl_pkg;

  // default sizing of the block
  localparam int MAX_CELLS_DEF  = 1024;
  localparam int COORD_BITS_DEF = 32;

  // fixed field widths
  localparam int CFG_W      = 11;
  localparam int REG_IDX_W  = 2;
  localparam int AXIS_W     = 2;
  localparam int ENTRY_W    = 11;
  localparam int INDEX_W    = 30;
  localparam int CELL_OUT_W = 10;
  localparam int NUM_AXES   = 3;

  // item opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOCATE = 1'b1;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

  // link passed from cell to cell while the linear index is built
  typedef struct packed {
    logic               go;
    logic               ok;
    logic [INDEX_W-1:0] acc;
  } rgpl_link_t;

endpackage

// ===== src/rect_grid_point_locate.sv =====
// top level of the rectilinear grid point locator: item control, config and output register
// depends on rgpl_pkg and rgpl_axis_cell
//
// A load item (one bound word) is taken while the block is idle. A query item
// occupies the block until its result is loaded: each axis cell reads its bound
// table one entry per cycle from its own memory port, the three scans run side by
// side, then the linear index passes through the z, y and x cells before landing
// in the output register. A finished result may wait in the output register while
// the next item is taken. No clearing pass after reset; bound entries must be
// loaded before a query reads them.
module rect_grid_point_locate #(
  parameter int MAX_CELLS  = rgpl_pkg::MAX_CELLS_DEF,
  parameter int COORD_BITS = rgpl_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [rgpl_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [rgpl_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic [rgpl_pkg::AXIS_W-1:0]        axis,
  input  logic [rgpl_pkg::ENTRY_W-1:0]       entry,
  input  logic signed [COORD_BITS-1:0]       bound_value,
  input  logic signed [COORD_BITS-1:0]       point_x,
  input  logic signed [COORD_BITS-1:0]       point_y,
  input  logic signed [COORD_BITS-1:0]       point_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [rgpl_pkg::INDEX_W-1:0]       cell_index,
  output logic [rgpl_pkg::CELL_OUT_W-1:0]    cell_col,
  output logic [rgpl_pkg::CELL_OUT_W-1:0]    cell_row,
  output logic [rgpl_pkg::CELL_OUT_W-1:0]    cell_plane
);
  import rgpl_pkg::*;

  localparam int IDX_W  = $clog2(MAX_CELLS + 1);
  localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_COMB = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [IDX_W-1:0]             cells [NUM_AXES];
  logic [IDX_W-1:0]             cfg_clamped;
  logic                         accept;
  logic                         start;
  logic                         load_ok;
  logic                         chain_go;
  logic                         out_load;
  logic [NUM_AXES-1:0]          done;
  logic [NUM_AXES-1:0]          wr_en;
  logic signed [COORD_BITS-1:0] key [NUM_AXES];
  logic [CELL_W-1:0]            cell_num [NUM_AXES];
  rgpl_link_t                   link [NUM_AXES+1];

  // cell count clamp: zero reads as one, large values saturate
  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = IDX_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_CELLS)) begin
      cfg_clamped = IDX_W'(MAX_CELLS);
    end else begin
      cfg_clamped = IDX_W'(cfg_data);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cells[0] <= IDX_W'(1);
      cells[1] <= IDX_W'(1);
      cells[2] <= IDX_W'(1);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_CELLS_X: cells[0] <= cfg_clamped;
        REG_CELLS_Y: cells[1] <= cfg_clamped;
        REG_CELLS_Z: cells[2] <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // input handshake and item decode
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign start    = accept && (opcode == OP_LOCATE);
  assign load_ok  = accept && (opcode == OP_LOAD) && (32'(entry) <= 32'(MAX_CELLS));
  assign chain_go = (state == ST_SCAN) && (&done);
  assign out_load = (state == ST_HOLD) && (!out_valid || !out_stall);

  assign key[0] = point_x;
  assign key[1] = point_y;
  assign key[2] = point_z;

  // sequencer for one query
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_SCAN;
      ST_SCAN: if (chain_go) state_next = ST_COMB;
      ST_COMB: if (link[0].go) state_next = ST_HOLD;
      ST_HOLD: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // head of the index chain enters at the z cell
  assign link[NUM_AXES] = '{go: chain_go, ok: 1'b1, acc: '0};

  // row of axis cells, chained z to y to x
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_cell
    assign wr_en[a] = load_ok && (axis == AXIS_W'(a));

    rgpl_axis_cell #(
      .MAX_CELLS  (MAX_CELLS),
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .CELL_W     (CELL_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en[a]),
      .wr_addr  (IDX_W'(entry)),
      .wr_data  (bound_value),
      .start    (start),
      .key_in   (key[a]),
      .cells    (cells[a]),
      .done     (done[a]),
      .cell_num (cell_num[a]),
      .link_in  (link[a+1]),
      .link_out (link[a])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found      <= link[0].ok;
      cell_index <= link[0].ok ? link[0].acc : '0;
      cell_col   <= link[0].ok ? CELL_OUT_W'(cell_num[0]) : '0;
      cell_row   <= link[0].ok ? CELL_OUT_W'(cell_num[1]) : '0;
      cell_plane <= link[0].ok ? CELL_OUT_W'(cell_num[2]) : '0;
    end
  end

endmodule

// ===== src/rgpl_axis_cell.sv =====
// one axis cell: bound table, linear interval scan, and one step of the index chain
// depends on rgpl_pkg
module rgpl_axis_cell #(
  parameter int MAX_CELLS  = rgpl_pkg::MAX_CELLS_DEF,
  parameter int COORD_BITS = rgpl_pkg::COORD_BITS_DEF,
  parameter int IDX_W      = $clog2(MAX_CELLS + 1),
  parameter int CELL_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_addr,
  input  logic signed [COORD_BITS-1:0]  wr_data,
  input  logic                          start,
  input  logic signed [COORD_BITS-1:0]  key_in,
  input  logic [IDX_W-1:0]              cells,
  output logic                          done,
  output logic [CELL_W-1:0]             cell_num,
  input  rgpl_pkg::rgpl_link_t          link_in,
  output rgpl_pkg::rgpl_link_t          link_out
);
  import rgpl_pkg::*;

  localparam int DEPTH = MAX_CELLS + 1;

  logic signed [COORD_BITS-1:0] mem [DEPTH];
  logic signed [COORD_BITS-1:0] rdata;
  logic signed [COORD_BITS-1:0] prev;
  logic signed [COORD_BITS-1:0] key;
  logic [IDX_W-1:0]             cnt;
  logic [IDX_W-1:0]             rd_idx;
  logic                         issuing;
  logic                         rd_vld;
  logic                         lo_ok;
  logic                         hi_ok;
  logic                         hit;
  logic                         link_go;
  logic                         link_ok;
  logic [INDEX_W-1:0]           link_acc;
  logic [INDEX_W-1:0]           acc_next;

  // bound table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[cnt];
  end

  // read sequencer walks entries 0..cells
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_vld  <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      issuing <= 1'b1;
      rd_vld  <= 1'b0;
      cnt     <= '0;
    end else begin
      rd_vld <= issuing;
      rd_idx <= cnt;
      if (issuing) begin
        if (cnt == cells) begin
          issuing <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // interval check on each returned bound, first match wins
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else if (start) begin
      done <= 1'b0;
      hit  <= 1'b0;
      key  <= key_in;
    end else if (rd_vld) begin
      prev <= rdata;
      if (rd_idx == '0) begin
        lo_ok <= (key >= rdata);
      end else if (!hit && (key >= prev) && (key < rdata)) begin
        hit      <= 1'b1;
        cell_num <= CELL_W'(rd_idx - 1'b1);
      end
      if (rd_idx == cells) begin
        hi_ok <= (key < rdata);
        done  <= 1'b1;
      end
    end
  end

  // horner step: acc * cells + own cell number
  assign acc_next = link_in.acc * INDEX_W'(cells) + INDEX_W'(cell_num);

  always_ff @(posedge clk) begin
    if (rst) begin
      link_go <= 1'b0;
    end else begin
      link_go <= link_in.go;
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.go) begin
      link_acc <= acc_next;
      link_ok  <= link_in.ok & lo_ok & hi_ok & hit;
    end
  end

  assign link_out = '{go: link_go, ok: link_ok, acc: link_acc};

endmodule
